// ===== src/bhpq_pkg.sv =====
// Package for the binary heap priority queue: beat structs, codes, defaults
// and the ordering compare. No dependencies; used by the top level in src and by the bench.
package bhpq_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int DATA_W           = 32;
   localparam int COUNT_OUT_W      = 7;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   // register word indexes
   localparam logic REG_MIN_HEAP = 1'b0;

   // operation codes
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic                     mode;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic                     heap_empty;
      logic [COUNT_OUT_W-1:0]   entry_count;
      status_type               status;
   } rsp_type;

   // True when the upper entry has to move below the lower one.
   function automatic logic out_of_order(input logic min_heap,
                                         input logic signed [DATA_W-1:0] upper,
                                         input logic signed [DATA_W-1:0] lower);
      logic result;
      if (min_heap) begin
         result = upper > lower;
      end else begin
         result = lower > upper;
      end
      return result;
   endfunction

endpackage

// ===== src/binary_heap_priority_queue_unit.sv =====
// Top level of the binary heap priority queue: sequencer, count, result register.
// Depends on bhpq_pkg and bhpq_ram (heap store).
//
//  channel  | direction | handshake                 | beat
//  ---------+-----------+---------------------------+------------------------------
//  req      | in        | req_valid / req_stall     | bhpq_pkg::req_type (mode, value)
//  rsp      | out       | rsp_valid / rsp_stall     | bhpq_pkg::rsp_type
//  csr      | in/out    | APB, pready tied high     | min_heap at byte address 0
//
// Sequence of an operation:
//   a push climbs one level at a time (one RAM read, compare and write back
//   per level, reads overlapped with writes); a push into an empty heap
//   writes the root straight away.
//   A pop moves the last entry to the root and sinks it, level by level: the
//   left and right child share the single RAM read port, so each level costs
//   two reads and a compare/write step (one read for a lone left child), and
//   the final position is written once its children have been checked.
//   Errors (pop on empty, push on full) and a last-entry pop skip the store.
// Reset: synchronous, clears the count, the sequencer and the result valid;
//   min_heap returns to 1. The store is not cleared: only live entries are read.
// Stalls: the result register holds a finished beat while the next item is
//   already being worked on; the sequencer only waits at its end if the
//   previous result has not been taken yet.
module binary_heap_priority_queue_unit #(
   parameter int CAPACITY = bhpq_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // item channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bhpq_pkg::req_type                   req_payload,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bhpq_pkg::rsp_type                   rsp_payload,
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bhpq_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bhpq_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bhpq_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int IDX_W  = $clog2(CAPACITY + 1);   // holds 0..CAPACITY
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int DW     = bhpq_pkg::DATA_W;
   localparam int CSR_ADDR_W_TOP = bhpq_pkg::CSR_ADDR_W - 1;

   typedef enum logic [2:0] {
      IDLE,
      UP_START,   // write at root or fetch parent
      UP_CMP,     // parent in rdata: move it down or settle
      POP_LOAD,   // last entry in rdata: becomes the hole value
      DN_ISSUE,   // fetch left child or settle
      DN_LEFT,    // left child in rdata, fetch right child
      DN_RIGHT,   // right child in rdata, pick winner
      DONE        // hand result to the output register
   } state_type;

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;       // one-indexed hole position
   logic [IDX_W-1:0]          count_ff, count_in;
   logic signed [DW-1:0]      hold_ff, hold_in;     // value that travels
   logic signed [DW-1:0]      lval_ff, lval_in;     // left child value
   logic signed [DW-1:0]      top_ff, top_in;       // shadow of entry 1
   bhpq_pkg::status_type      status_ff, status_in;
   logic                      min_heap_ff, min_heap_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   bhpq_pkg::rsp_type         rsp_ff, rsp_in;

   // RAM ports
   logic                      ram_we, ram_re;
   logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
   logic signed [DW-1:0]      ram_wdata;
   logic [DW-1:0]             ram_rdata;
   logic signed [DW-1:0]      rdata;

   // index arithmetic
   logic [IDX_W-1:0]          parent, grand;
   logic [IDX_W:0]            left, right, n_ext;
   logic                      req_fire, csr_write, out_free;
   logic                      pick_left, pick_right;
   logic signed [DW-1:0]      best_val;

   assign rdata     = ram_rdata;
   assign parent    = idx_ff >> 1;
   assign grand     = idx_ff >> 2;
   assign left      = {idx_ff, 1'b0};
   assign right     = {idx_ff, 1'b1};
   assign n_ext     = {1'b0, count_ff};
   assign req_stall = (state_ff != IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr[CSR_ADDR_W_TOP] == bhpq_pkg::REG_MIN_HEAP);

   // winner among hole value, left and right (left preferred, strict order)
   assign pick_left  = bhpq_pkg::out_of_order(min_heap_ff, hold_ff, lval_ff);
   assign best_val   = pick_left ? lval_ff : hold_ff;
   assign pick_right = bhpq_pkg::out_of_order(min_heap_ff, best_val, rdata);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      hold_in      = hold_ff;
      lval_in      = lval_ff;
      top_in       = top_ff;
      status_in    = status_ff;
      min_heap_in  = min_heap_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = ADDR_W'(idx_ff - 1'b1);
      ram_raddr    = '0;
      ram_wdata    = hold_ff;

      if (csr_write) begin
         min_heap_in = csr_pwdata[0];
      end

      unique case (state_ff)
         IDLE: begin
            if (req_fire) begin
               status_in = bhpq_pkg::STATUS_OK;
               if (req_payload.mode == bhpq_pkg::MODE_PUSH) begin
                  if (count_ff == IDX_W'(CAPACITY)) begin
                     status_in = bhpq_pkg::STATUS_FULL;
                     state_in  = DONE;
                  end else begin
                     count_in = count_ff + 1'b1;
                     idx_in   = count_ff + 1'b1;
                     hold_in  = req_payload.value;
                     state_in = UP_START;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = bhpq_pkg::STATUS_EMPTY;
                     state_in  = DONE;
                  end else if (count_ff == IDX_W'(1)) begin
                     count_in = '0;
                     state_in = DONE;
                  end else begin
                     // last entry sits at address count-1
                     count_in  = count_ff - 1'b1;
                     ram_re    = 1'b1;
                     ram_raddr = ADDR_W'(count_ff - 1'b1);
                     state_in  = POP_LOAD;
                  end
               end
            end
         end
         UP_START: begin
            if (idx_ff == IDX_W'(1)) begin
               ram_we   = 1'b1;
               state_in = DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = ADDR_W'(parent - 1'b1);
               state_in  = UP_CMP;
            end
         end
         UP_CMP: begin
            ram_we = 1'b1;
            if (bhpq_pkg::out_of_order(min_heap_ff, rdata, hold_ff)) begin
               ram_wdata = rdata;
               idx_in    = parent;
               if (parent == IDX_W'(1)) begin
                  state_in = UP_START;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = ADDR_W'(grand - 1'b1);
               end
            end else begin
               state_in = DONE;
            end
         end
         POP_LOAD: begin
            hold_in  = rdata;
            idx_in   = IDX_W'(1);
            state_in = DN_ISSUE;
         end
         DN_ISSUE: begin
            if (left <= n_ext) begin
               ram_re    = 1'b1;
               ram_raddr = ADDR_W'(left - 1'b1);
               state_in  = DN_LEFT;
            end else begin
               ram_we   = 1'b1;
               state_in = DONE;
            end
         end
         DN_LEFT: begin
            lval_in = rdata;
            if (right <= n_ext) begin
               ram_re    = 1'b1;
               ram_raddr = ADDR_W'(right - 1'b1);
               state_in  = DN_RIGHT;
            end else begin
               ram_we = 1'b1;
               if (bhpq_pkg::out_of_order(min_heap_ff, hold_ff, rdata)) begin
                  ram_wdata = rdata;
                  idx_in    = IDX_W'(left);
                  state_in  = DN_ISSUE;
               end else begin
                  state_in = DONE;
               end
            end
         end
         DN_RIGHT: begin
            ram_we = 1'b1;
            if (pick_right) begin
               ram_wdata = rdata;
               idx_in    = IDX_W'(right);
               state_in  = DN_ISSUE;
            end else if (pick_left) begin
               ram_wdata = lval_ff;
               idx_in    = IDX_W'(left);
               state_in  = DN_ISSUE;
            end else begin
               state_in = DONE;
            end
         end
         DONE: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.top_value       = (count_ff != '0) ? top_ff : '0;
               rsp_in.heap_empty      = (count_ff == '0);
               rsp_in.entry_count     = bhpq_pkg::COUNT_OUT_W'(count_ff);
               rsp_in.status          = status_ff;
               state_in               = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      // keep a copy of the root so the result needs no extra read
      if (ram_we && (ram_waddr == '0)) begin
         top_in = ram_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         min_heap_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         min_heap_ff  <= min_heap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff    <= idx_in;
      hold_ff   <= hold_in;
      lval_ff   <= lval_in;
      top_ff    <= top_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   bhpq_ram #(
      .WIDTH (DW),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr[CSR_ADDR_W_TOP] == bhpq_pkg::REG_MIN_HEAP) ?
                        bhpq_pkg::CSR_DATA_W'(min_heap_ff) : '0;

   // count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IDX_W'(CAPACITY))
      else $error("entry count beyond capacity");

   // the store is only written while an item is in flight
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE || state_ff == DONE) |-> !ram_we)
      else $error("store written outside an operation");

   // sift-down hole stays inside the live heap
   a_hole_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DN_ISSUE || state_ff == DN_LEFT || state_ff == DN_RIGHT) |->
      (idx_ff != '0 && idx_ff <= count_ff))
      else $error("sift-down index outside heap");

   // an empty result reports a zero top
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.heap_empty) |-> (rsp_ff.top_value == '0))
      else $error("empty heap with nonzero top");

   // a dropped push only happens at capacity
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && rsp_ff.status == bhpq_pkg::STATUS_FULL) |->
      (count_ff == IDX_W'(CAPACITY)))
      else $error("full status below capacity");

endmodule

// ===== src/bhpq_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies. Read of an address written in the same cycle returns old data.
module bhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sim/binary_heap_priority_queue_unit_tb.sv =====
// Self-checking bench for binary_heap_priority_queue_unit: a directed table, then
// random push/pop runs under both orderings, each result checked against a heap predictor
// or a hand-written row. Depends on bhpq_pkg and the RTL in src; reads no files.
`timescale 1ns / 100ps

module binary_heap_priority_queue_unit_tb;

   localparam int HEAP_DEPTH   = bhpq_pkg::CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS = 850;
   localparam int TAIL_ITEMS   = 100;   // last stretch runs with no idling
   localparam int SETTLE_CYC   = 40;    // covers the slowest pop
   localparam logic [bhpq_pkg::CSR_ADDR_W-1:0] MIN_HEAP_ADDR =
      bhpq_pkg::CSR_ADDR_W'(4 * bhpq_pkg::REG_MIN_HEAP);

   typedef enum int {FILL_RUN, DRAIN_RUN, MIXED_RUN} run_kind_type;

   typedef struct {
      int                order_sel;   // -1: leave ordering alone, else write it first
      bhpq_pkg::req_type beat;
      bit                typed;       // want holds a hand-written expectation
      bhpq_pkg::rsp_type want;
   } stim_row_type;

   logic                            clock;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_stall;
   bhpq_pkg::req_type               req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_stall   = 1'b0;
   bhpq_pkg::rsp_type               rsp_payload;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [bhpq_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [bhpq_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [bhpq_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // predictor state: its own copy of the heap and the ordering bit
   logic signed [bhpq_pkg::DATA_W-1:0] heap_mem [HEAP_DEPTH];
   int unsigned                        heap_fill = 0;
   logic                               min_order = 1'b1;

   bhpq_pkg::rsp_type heap_snap_q [$];   // expected heap snapshots, oldest first
   stim_row_type      stim_rows [$];
   int                fail_count  = 0;
   int                items_sent  = 0;
   bit                idle_enable = 1'b0;
   int                stall_left  = 0;

   binary_heap_priority_queue_unit #(
      .CAPACITY(HEAP_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
   endfunction

   // true when the upper entry belongs below the lower one
   function automatic logic must_swap(logic signed [bhpq_pkg::DATA_W-1:0] upper,
                                      logic signed [bhpq_pkg::DATA_W-1:0] lower);
      return min_order ? (upper > lower) : (lower > upper);
   endfunction

   // one-indexed positions
   function automatic void heap_swap(int unsigned a, int unsigned b);
      logic signed [bhpq_pkg::DATA_W-1:0] t;
      t             = heap_mem[a-1];
      heap_mem[a-1] = heap_mem[b-1];
      heap_mem[b-1] = t;
   endfunction

   // Applies one push/pop to the predictor heap, returns the snapshot after it.
   function automatic bhpq_pkg::rsp_type heap_apply(bhpq_pkg::req_type beat);
      bhpq_pkg::rsp_type snap;
      int unsigned       pos;
      int unsigned       kid;
      int unsigned       best;
      bit                settled;
      snap.status = bhpq_pkg::STATUS_OK;
      if (beat.mode == bhpq_pkg::MODE_PUSH) begin
         if (heap_fill >= HEAP_DEPTH) begin
            snap.status = bhpq_pkg::STATUS_FULL;
         end else begin
            heap_fill++;
            pos = heap_fill;
            heap_mem[pos-1] = beat.value;
            while (pos > 1 && must_swap(heap_mem[pos/2-1], heap_mem[pos-1])) begin
               heap_swap(pos / 2, pos);
               pos = pos / 2;
            end
         end
      end else if (heap_fill == 0) begin
         snap.status = bhpq_pkg::STATUS_EMPTY;
      end else begin
         // last entry to the root, then sift down; left child wins ties
         heap_mem[0] = heap_mem[heap_fill-1];
         heap_fill--;
         pos     = 1;
         settled = (heap_fill == 0);
         while (!settled) begin
            best = pos;
            kid  = 2 * pos;
            if (kid <= heap_fill && must_swap(heap_mem[pos-1], heap_mem[kid-1])) begin
               best = kid;
            end
            if (kid + 1 <= heap_fill && must_swap(heap_mem[best-1], heap_mem[kid])) begin
               best = kid + 1;
            end
            if (best == pos) begin
               settled = 1'b1;
            end else begin
               heap_swap(best, pos);
               pos = best;
            end
         end
      end
      snap.top_value   = (heap_fill != 0) ? heap_mem[0] : '0;
      snap.heap_empty  = (heap_fill == 0);
      snap.entry_count = bhpq_pkg::COUNT_OUT_W'(heap_fill);
      return snap;
   endfunction

   function automatic void add_row(int order_sel, logic op,
                                   logic signed [bhpq_pkg::DATA_W-1:0] val,
                                   bit typed = 1'b0,
                                   logic signed [bhpq_pkg::DATA_W-1:0] top = '0,
                                   logic empty = 1'b0, int cnt = 0,
                                   bhpq_pkg::status_type st = bhpq_pkg::STATUS_OK);
      stim_row_type r;
      r.order_sel         = order_sel;
      r.beat.mode         = op;
      r.beat.value        = val;
      r.typed             = typed;
      r.want.top_value    = top;
      r.want.heap_empty   = empty;
      r.want.entry_count  = bhpq_pkg::COUNT_OUT_W'(cnt);
      r.want.status       = st;
      stim_rows.insert(stim_rows.size(), r);
   endfunction

   // Mostly full-range values, some extremes, some tiny ones to force ties.
   function automatic logic signed [bhpq_pkg::DATA_W-1:0] pick_value();
      logic signed [bhpq_pkg::DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0:       v = 32'sh8000_0000;
               1:       v = 32'sh7FFF_FFFF;
               2:       v = 32'sh0;
               3:       v = -32'sd1;
               default: v = 32'sd1;
            endcase
         end
         1, 2, 3: v = int'($urandom_range(0, 8)) - 4;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Presents one beat, holds it until taken, then records what it should produce.
   task automatic send_item(bhpq_pkg::req_type beat, bit typed,
                            bhpq_pkg::rsp_type typed_want);
      bhpq_pkg::rsp_type predicted;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
      predicted = heap_apply(beat);
      heap_snap_q.insert(heap_snap_q.size(), typed ? typed_want : predicted);
   endtask

   // Every item yields a result, so an empty queue means the block is idle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (heap_snap_q.size() != 0) @(posedge clock);
   endtask

   // Write min_heap (junk in the upper bits), then read it back in the same
   // transfer sequence so psel never toggles twice in a step.
   task automatic set_order(logic order);
      logic [bhpq_pkg::CSR_DATA_W-1:0] wdata;
      logic [bhpq_pkg::CSR_DATA_W-1:0] rdata;
      wdata    = $urandom;
      wdata[0] = order;
      min_order = order;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MIN_HEAP_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rdata !== {{(bhpq_pkg::CSR_DATA_W-1){1'b0}}, order}) begin
         note_failure($sformatf("min_heap readback exp %0h got %0h", order, rdata));
      end
   endtask

   // Result side: stall in random bursts, check every beat taken.
   always @(posedge clock) begin : rsp_check
      bhpq_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (heap_snap_q.size() == 0) begin
            note_failure($sformatf("unexpected beat: top %0d empty %0b count %0d status %0d",
                                   rsp_payload.top_value, rsp_payload.heap_empty,
                                   rsp_payload.entry_count, rsp_payload.status));
         end else begin
            want = heap_snap_q.pop_front();
            if (rsp_payload.top_value   !== want.top_value   ||
                rsp_payload.heap_empty  !== want.heap_empty  ||
                rsp_payload.entry_count !== want.entry_count ||
                rsp_payload.status      !== want.status) begin
               note_failure($sformatf({"exp top %0d empty %0b count %0d status %0d, ",
                                       "got top %0d empty %0b count %0d status %0d"},
                                      want.top_value, want.heap_empty,
                                      want.entry_count, want.status,
                                      rsp_payload.top_value, rsp_payload.heap_empty,
                                      rsp_payload.entry_count, rsp_payload.status));
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 19);
      end
      rsp_stall <= (stall_left > 0);
   end

   initial begin : stimulus
      bhpq_pkg::req_type beat;
      run_kind_type      kind;
      int                push_pct;
      int                run_len;
      int                run_idx;
      bit                tail_run;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: pop on empty, field extremes, duplicates, drain to empty
      // (last-entry pop), then max ordering, then ordering flipped with
      // entries still held.
      add_row(-1, bhpq_pkg::MODE_POP,  32'sh0,         1'b1, 32'sh0,         1'b1, 0,
              bhpq_pkg::STATUS_EMPTY);
      add_row(-1, bhpq_pkg::MODE_PUSH, 32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF, 1'b0, 1,
              bhpq_pkg::STATUS_OK);
      add_row(-1, bhpq_pkg::MODE_PUSH, 32'sh8000_0000, 1'b1, 32'sh8000_0000, 1'b0, 2,
              bhpq_pkg::STATUS_OK);
      add_row(-1, bhpq_pkg::MODE_PUSH, 32'sh0,         1'b1, 32'sh8000_0000, 1'b0, 3,
              bhpq_pkg::STATUS_OK);
      add_row(-1, bhpq_pkg::MODE_PUSH, -32'sd1,        1'b1, 32'sh8000_0000, 1'b0, 4,
              bhpq_pkg::STATUS_OK);
      add_row(-1, bhpq_pkg::MODE_PUSH, 32'sd1);
      add_row(-1, bhpq_pkg::MODE_PUSH, 32'sh8000_0000);
      add_row(-1, bhpq_pkg::MODE_PUSH, 32'sh7FFF_FFFF);
      repeat (7) add_row(-1, bhpq_pkg::MODE_POP, $urandom);
      add_row(-1, bhpq_pkg::MODE_POP,  32'shFFFF_FFFF, 1'b1, 32'sh0,         1'b1, 0,
              bhpq_pkg::STATUS_EMPTY);
      add_row(-1, bhpq_pkg::MODE_PUSH, -32'sd5,        1'b1, -32'sd5,        1'b0, 1,
              bhpq_pkg::STATUS_OK);
      add_row(-1, bhpq_pkg::MODE_POP,  32'sh0,         1'b1, 32'sh0,         1'b1, 0,
              bhpq_pkg::STATUS_OK);
      add_row(0,  bhpq_pkg::MODE_PUSH, 32'sh8000_0000, 1'b1, 32'sh8000_0000, 1'b0, 1,
              bhpq_pkg::STATUS_OK);
      add_row(-1, bhpq_pkg::MODE_PUSH, 32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF, 1'b0, 2,
              bhpq_pkg::STATUS_OK);
      add_row(-1, bhpq_pkg::MODE_PUSH, 32'sh0,         1'b1, 32'sh7FFF_FFFF, 1'b0, 3,
              bhpq_pkg::STATUS_OK);
      add_row(1,  bhpq_pkg::MODE_PUSH, 32'sd3);
      repeat (3) add_row(-1, bhpq_pkg::MODE_POP, $urandom);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].order_sel >= 0) begin
            drain_results();
            set_order(stim_rows[i].order_sel[0]);
         end
         send_item(stim_rows[i].beat, stim_rows[i].typed, stim_rows[i].want);
      end

      // Random runs: each starts idle with a fresh ordering write; fill runs are mostly
      // pushes, drain runs mostly pops. The first run fills.
      run_idx = 0;
      while (items_sent < RANDOM_ITEMS) begin
         tail_run = (items_sent >= RANDOM_ITEMS - TAIL_ITEMS);
         drain_results();
         set_order(($urandom_range(0, 3) == 0) ? min_order : !min_order);
         idle_enable = tail_run ? 1'b0 : ($urandom_range(0, 3) != 0);
         kind = (run_idx == 0) ? FILL_RUN : run_kind_type'($urandom_range(0, 2));
         case (kind)
            FILL_RUN:  push_pct = 90;
            DRAIN_RUN: push_pct = 15;
            default:   push_pct = 55;
         endcase
         run_len = tail_run ? RANDOM_ITEMS - items_sent : $urandom_range(40, 120);
         repeat (run_len) begin
            beat.mode  = ($urandom_range(0, 99) < push_pct) ? bhpq_pkg::MODE_PUSH :
                                                              bhpq_pkg::MODE_POP;
            beat.value = pick_value();
            send_item(beat, 1'b0, '0);
            items_sent++;
         end
         run_idx++;
      end

      drain_results();
      repeat (SETTLE_CYC) @(posedge clock);
      if (fail_count == 0 && heap_snap_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
